### rtl/sqp_pkg.sv
package sqp_pkg;

	// Register indexes on the configuration write channel.
	localparam logic [1:0] CFG_SCALE = 2'd0;
	localparam logic [1:0] CFG_MODE  = 2'd1;

	// Clamp limits as magnitudes.
	localparam logic [7:0] HI_INT8 = 8'd127;
	localparam logic [7:0] HI_INT4 = 8'd7;

	// Quotient bits: one integer bit, 23 fraction bits, guard and round.
	localparam logic [4:0] QUO_LAST = 5'd25;

	typedef enum logic [1:0] {
		KIND_BAD,
		KIND_ZERO,
		KIND_DIV
	} kind_t;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
		logic        int4;
		kind_t       kind;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_PRE,
		ST_DIV,
		ST_ROUND,
		ST_CODE,
		ST_PACK
	} state_t;

	// A scale is bad when it is not finite, negative, or zero of either sign.
	function automatic logic scale_bad(input logic [31:0] b);
		return (b[30:23] == 8'hff) || b[31] || (b[30:0] == 31'd0);
	endfunction

	// A value that is not finite, or is zero, always quantizes to zero.
	function automatic logic value_trivial(input logic [31:0] b);
		return (b[30:23] == 8'hff) || (b[30:0] == 31'd0);
	endfunction

endpackage

### rtl/sqp_front.sv
module sqp_front import sqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic [31:0] scale_bits,
	input  logic        bit_mode,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      item_in;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem[rd_q];

	always_comb begin
		item_in.value = s_tdata;
		item_in.last  = s_tlast;
		item_in.int4  = bit_mode;
		if (scale_bad(scale_bits)) begin
			item_in.kind = KIND_BAD;
		end else if (value_trivial(s_tdata)) begin
			item_in.kind = KIND_ZERO;
		end else begin
			item_in.kind = KIND_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

### rtl/sqp_back.sv
module sqp_back import sqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	input  logic [31:0] scale_bits,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	state_t             state_q;
	state_t             state_d;
	item_t              item_q;
	logic [23:0]        nv_q;
	logic [23:0]        ns_q;
	logic signed [9:0]  ev_q;
	logic signed [9:0]  es_q;
	logic [25:0]        rem_q;
	logic [25:0]        quo_q;
	logic [4:0]         cnt_q;
	logic signed [9:0]  exp_q;
	logic [23:0]        man_q;
	logic [7:0]         code_q;
	logic [3:0]         held_q;
	logic               pend_q;
	logic               out_valid_q;
	logic [7:0]         out_code_q;
	logic               out_last_q;
	logic               out_bad_q;

	// Division step.
	logic               ge;
	logic [25:0]        rem_sub;
	// Mantissa rounding.
	logic               rnd_inc;
	logic [24:0]        rnd_sum;
	// Code extraction.
	logic [7:0]         hi;
	logic signed [9:0]  sh_w;
	logic [4:0]         sh;
	logic [4:0]         hidx;
	logic [23:0]        mask;
	logic [7:0]         t_int;
	logic               half;
	logic               rest;
	logic [8:0]         r9;
	logic [7:0]         mag;
	logic [7:0]         code_d;
	// Packing.
	logic               emit;
	logic [7:0]         pk_code;
	logic               pk_last;
	logic               pk_bad;
	logic [3:0]         held_d;
	logic               pend_d;
	logic               out_free;
	logic               pack_fire;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_code_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;
	assign out_free = !out_valid_q || m_tready;

	assign ge      = rem_q >= {2'b00, ns_q};
	assign rem_sub = ge ? (rem_q - {2'b00, ns_q}) : rem_q;

	assign rnd_inc = quo_q[1] && (quo_q[0] || (rem_q != 26'd0) || quo_q[2]);
	assign rnd_sum = {1'b0, quo_q[25:2]} + {24'd0, rnd_inc};

	always_comb begin
		hi     = item_q.int4 ? HI_INT4 : HI_INT8;
		sh_w   = 10'sd23 - exp_q;
		sh     = sh_w[4:0];
		hidx   = sh - 5'd1;
		mask   = (24'd1 << hidx) - 24'd1;
		t_int  = 8'(man_q >> sh);
		half   = man_q[hidx];
		rest   = (man_q & mask) != 24'd0;
		r9     = {1'b0, t_int} + {8'd0, half && (rest || t_int[0])};
		if (exp_q >= 10'sd128) begin
			mag = 8'd0;
		end else if (exp_q >= 10'sd8) begin
			mag = hi;
		end else if (exp_q < -10'sd1) begin
			mag = 8'd0;
		end else if (r9 > {1'b0, hi}) begin
			mag = hi;
		end else begin
			mag = r9[7:0];
		end
		code_d = item_q.value[31] ? (8'd0 - mag) : mag;
	end

	always_comb begin
		emit    = 1'b1;
		pk_code = code_q;
		pk_last = item_q.last;
		pk_bad  = 1'b0;
		held_d  = 4'd0;
		pend_d  = 1'b0;
		if (item_q.kind == KIND_BAD) begin
			pk_code = 8'd0;
			pk_bad  = 1'b1;
		end else if (item_q.int4) begin
			if (!pend_q) begin
				pk_code = {4'd0, code_q[3:0]};
				pk_last = 1'b1;
				if (!item_q.last) begin
					emit   = 1'b0;
					held_d = code_q[3:0];
					pend_d = 1'b1;
				end
			end else begin
				pk_code = {code_q[3:0], held_q};
			end
		end
		pack_fire = (state_q == ST_PACK) && (!emit || out_free);
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (q_item.kind == KIND_DIV) ? ST_NORM : ST_PACK;
				end
			end
			ST_NORM: begin
				if (nv_q[23] && ns_q[23]) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == 5'd0) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_CODE;
			ST_CODE:  state_d = ST_PACK;
			ST_PACK: begin
				if (pack_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				code_q <= 8'd0;
				if (q_item.value[30:23] == 8'd0) begin
					nv_q <= {1'b0, q_item.value[22:0]};
					ev_q <= 10'sd1;
				end else begin
					nv_q <= {1'b1, q_item.value[22:0]};
					ev_q <= $signed({2'b00, q_item.value[30:23]});
				end
				if (scale_bits[30:23] == 8'd0) begin
					ns_q <= {1'b0, scale_bits[22:0]};
					es_q <= 10'sd1;
				end else begin
					ns_q <= {1'b1, scale_bits[22:0]};
					es_q <= $signed({2'b00, scale_bits[30:23]});
				end
			end
			ST_NORM: begin
				if (!nv_q[23]) begin
					nv_q <= {nv_q[22:0], 1'b0};
					ev_q <= ev_q - 10'sd1;
				end
				if (!ns_q[23]) begin
					ns_q <= {ns_q[22:0], 1'b0};
					es_q <= es_q - 10'sd1;
				end
			end
			ST_PRE: begin
				cnt_q <= QUO_LAST;
				quo_q <= 26'd0;
				if (nv_q < ns_q) begin
					rem_q <= {1'b0, nv_q, 1'b0};
					exp_q <= ev_q - es_q - 10'sd1;
				end else begin
					rem_q <= {2'b00, nv_q};
					exp_q <= ev_q - es_q;
				end
			end
			ST_DIV: begin
				quo_q <= {quo_q[24:0], ge};
				rem_q <= {rem_sub[24:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			ST_ROUND: begin
				if (rnd_sum[24]) begin
					man_q <= 24'h800000;
					exp_q <= exp_q + 10'sd1;
				end else begin
					man_q <= rnd_sum[23:0];
				end
			end
			ST_CODE: code_q <= code_d;
			ST_PACK: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 4'd0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pack_fire) begin
				held_q <= held_d;
				pend_q <= pend_d;
			end
			if (pack_fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pack_fire && emit) begin
			out_code_q <= pk_code;
			out_last_q <= pk_last;
			out_bad_q  <= pk_bad;
		end
	end

endmodule

### rtl/symmetric_quantize_pack_top.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    tdata[31:0] value_bits, tlast last_value
// m_*       out        m_tvalid/m_tready    tdata[7:0] code_byte, tlast last_byte,
//                                           tuser bad_scale
// cfg_*     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A value that needs the divide holds the back end through these steps in order: it is
// taken from the queue, normalized by one-bit shifts (more than one shift only for subnormal
// operands), set up, divided by the bit-serial restoring divider, then rounded, coded and
// packed. Bad-scale, zero and non-finite values go from the queue straight to the pack step.
// The front queue holds two transactions, so input is accepted while the back end divides
// or the output register waits, until the queue fills. Reset is asynchronous and clears
// the queue, the held nibble and output valid; registers return to scale 1.0 and INT4 mode.
module symmetric_quantize_pack_top import sqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // value_bits
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // code_byte
	output logic        m_tlast,
	output logic        m_tuser,    // bad_scale
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] scale_q;
	logic        mode_q;
	logic        q_valid;
	item_t       q_item;
	logic        q_pop;

	// Configuration transactions are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'h3f800000;
			mode_q  <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SCALE) begin
				scale_q <= cfg_data;
			end else if (cfg_index == CFG_MODE) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	// The front end classifies each value against the current scale and queues it.
	sqp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.scale_bits (scale_q),
		.bit_mode   (mode_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// The back end divides, rounds, clamps and packs into the output register.
	sqp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.scale_bits (scale_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

### rtl/sqp_checker.sv
module sqp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// A stalled output transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// A stalled output transaction keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// A bad scale always yields a zero code.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'd0)
		else $error("nonzero code with bad scale");

	// Nothing is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind symmetric_quantize_pack_top sqp_checker u_sqp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
